@@ rtl/i2rd_pkg.sv @@
// shared types, constants and the digit-to-ascii map for the radix digit unit
// no dependencies
package i2rd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CHUNK_BITS     = 8;
    localparam int RADIX_BITS     = 5;
    localparam int DIGIT_BITS     = 4;
    localparam int CHAR_BITS      = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } back_state_t;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic empty;
    } queue_head_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DIGIT_TEN)
            c = CHAR_ZERO + CHAR_BITS'(d);
        else
            c = CHAR_A + CHAR_BITS'(d - DIGIT_TEN);
        return c;
    endfunction

endpackage

@@ rtl/i2rd_front.sv @@
// front end: accepts items, classifies them and queues them for the back end
// depends on i2rd_pkg
module i2rd_front
    import i2rd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   value,
    output logic                    busy,
    input  logic                    pop,
    output queue_head_t             head,
    output logic [VALUE_BITS-2:0]   head_mag
);

    localparam int MAG_BITS  = VALUE_BITS - 1;
    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    logic [MAG_BITS-1:0] mag_reg [QUEUE_DEPTH];
    logic                empty_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                push;
    logic                do_pop;
    logic                item_empty;

    // non-positive items give no digits
    assign item_empty = (value == '0) || value[VALUE_BITS-1];

    assign busy   = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.empty = empty_reg[rd_ptr_reg];
    assign head_mag   = mag_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_reg[wr_ptr_reg]   <= value[MAG_BITS-1:0];
            empty_reg[wr_ptr_reg] <= item_empty;
        end
    end

endmodule

@@ rtl/i2rd_back.sv @@
// back end: chunked long division by the radix, digit store, reverse emission
// depends on i2rd_pkg
module i2rd_back
    import i2rd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [RADIX_BITS-1:0]   radix,
    input  queue_head_t             head,
    input  logic [VALUE_BITS-2:0]   head_mag,
    output logic                    pop,
    output logic                    strobe,
    output logic [CHAR_BITS-1:0]    digit_char,
    output logic                    last_digit,
    output logic                    empty_res
);

    localparam int MAG_BITS   = VALUE_BITS - 1;
    localparam int MAX_DIGITS = MAG_BITS;
    localparam int STEPS      = (MAG_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WORK_BITS  = STEPS * CHUNK_BITS;
    localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_BITS  = $clog2(MAX_DIGITS);
    localparam int STEP_BITS  = (STEPS > 1) ? $clog2(STEPS) : 1;

    back_state_t            state_reg, state_next;
    logic [WORK_BITS-1:0]   work_reg, work_next;
    logic [DIGIT_BITS-1:0]  rem_reg, rem_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [ADDR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                   strobe_reg, strobe_next;
    logic                   last_reg, last_next;
    logic                   empty_reg, empty_next;
    logic [DIGIT_BITS-1:0]  rdata_reg;
    logic [DIGIT_BITS-1:0]  digit_mem [MAX_DIGITS];

    logic [WORK_BITS-1:0]   work_div;
    logic [DIGIT_BITS-1:0]  rem_div;
    logic [CHUNK_BITS-1:0]  q_chunk;
    logic [RADIX_BITS-1:0]  rem_wide;
    logic                   step_last;
    logic [CNT_BITS-1:0]    count_inc;
    logic                   conv_done;
    logic                   mem_we;
    logic                   mem_re;

    // one chunk of restoring division, msb first
    always_comb
    begin
        rem_wide = RADIX_BITS'(rem_reg);
        q_chunk  = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            rem_wide = {rem_wide[DIGIT_BITS-1:0], work_reg[WORK_BITS-1-i]};
            if (rem_wide >= radix)
            begin
                rem_wide = rem_wide - radix;
                q_chunk[CHUNK_BITS-1-i] = 1'b1;
            end
        end
        rem_div  = rem_wide[DIGIT_BITS-1:0];
        work_div = (work_reg << CHUNK_BITS) | WORK_BITS'(q_chunk);
    end

    assign step_last = (step_reg == STEP_BITS'(STEPS - 1));
    assign count_inc = count_reg + 1'b1;
    assign conv_done = (work_div == '0) || (count_inc == CNT_BITS'(MAX_DIGITS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && !head.empty)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (step_last && conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (rd_ptr_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        work_next   = work_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        empty_next  = empty_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.empty)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        empty_next  = 1'b1;
                    end
                    else
                    begin
                        work_next  = WORK_BITS'(head_mag);
                        rem_next   = '0;
                        step_next  = '0;
                        count_next = '0;
                    end
                end
            end
            ST_DIVIDE:
            begin
                work_next = work_div;
                rem_next  = rem_div;
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    mem_we     = 1'b1;
                    count_next = count_inc;
                    rem_next   = '0;
                    step_next  = '0;
                    if (conv_done)
                        rd_ptr_next = count_reg[ADDR_BITS-1:0];
                end
            end
            ST_EMIT:
            begin
                mem_re      = 1'b1;
                strobe_next = 1'b1;
                last_next   = (rd_ptr_reg == '0);
                empty_next  = 1'b0;
                rd_ptr_next = rd_ptr_reg - 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    // digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[ADDR_BITS-1:0]] <= rem_div;
        if (mem_re)
            rdata_reg <= digit_mem[rd_ptr_reg];
    end

    assign strobe     = strobe_reg;
    assign digit_char = empty_reg ? '0 : digit_to_char(rdata_reg);
    assign last_digit = last_reg;
    assign empty_res  = empty_reg;

endmodule

@@ rtl/integer_to_radix_digits_unit.sv @@
// top level of the integer to radix digit converter
// depends on i2rd_pkg, i2rd_front, i2rd_back
//
// Converts a signed integer into ascii digits ('0'-'9', 'A'-'F') in the
// configured radix, most significant digit first. An item is taken when start
// is high and busy is low. Each digit appears for exactly one cycle with
// digit_strobe high; the receiver cannot stall, so it must take every strobe.
// last_digit marks the final digit of an item. A zero or negative item gives
// a single result with empty_res and last_digit high and digit_char zero.
// The back end divides by the radix CHUNK_BITS bits per cycle, making a pass
// over the whole magnitude for each digit, and the digits then stream out one
// per cycle. The back end takes an item from the queue at the earliest in the
// cycle after start is accepted; after a positive item it takes the next one
// in the cycle that shows the last digit. A non-positive item does not take
// the back end out of its idle state, and its result comes out in the next
// cycle. A two-entry queue lets start be taken while the back end is still
// converting; busy rises only when that queue is full.
// The radix register resets to 10; 0 and 1 act as 2, 17 and up act as 16.
// Write it only while the block has no work in flight.
module integer_to_radix_digits_unit
    import i2rd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // item channel
    input  logic                    start,
    output logic                    busy,
    input  logic [VALUE_BITS-1:0]   value,
    // radix register write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [RADIX_BITS-1:0]   cfg_data,
    // results
    output logic                    digit_strobe,
    output logic [CHAR_BITS-1:0]    digit_char,
    output logic                    last_digit,
    output logic                    empty_res
);

    logic [RADIX_BITS-1:0]  radix_reg, radix_next;
    logic [RADIX_BITS-1:0]  radix_eff;
    queue_head_t            head;
    logic [VALUE_BITS-2:0]  head_mag;
    logic                   pop;

    // the radix register accepts every write, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid && cfg_ready)
            radix_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else
            radix_reg <= radix_next;
    end

    // saturate the radix into the supported range
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    // accept and classify, queue up to two items
    i2rd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .pop      (pop),
        .head     (head),
        .head_mag (head_mag)
    );

    // divide, store digits, emit in reverse
    i2rd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix      (radix_eff),
        .head       (head),
        .head_mag   (head_mag),
        .pop        (pop),
        .strobe     (digit_strobe),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .empty_res  (empty_res)
    );

endmodule

@@ bench/testbench.sv @@
// self-checking bench for integer_to_radix_digits_unit: directed table, then random phases
// depends on i2rd_pkg and the rtl top level; predicts digit runs in plain sv or takes them from the table
`timescale 1ns / 100ps

module testbench;
    import i2rd_pkg::*;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // predicted by the bench's own digit divider
        CHK_EMPTY,   // non-positive item, one empty result
        CHK_TEXT     // digit string typed into the row
    } row_check_t;

    // one row of the directed stimulus table
    typedef struct packed {
        logic                  set_radix;  // write the radix register before the item
        logic [RADIX_BITS-1:0] radix;
        logic [31:0]           value;
        row_check_t            check;
        logic [79:0]           text;       // up to ten ascii digits, right aligned
    } stim_row_t;

    // one result as seen on the output ports
    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 last_digit;
        logic                 empty_res;
    } digit_result_t;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES   = 11;
    localparam int PHASE_ITEMS  = 10;
    localparam int MAX_DIGITS   = 31;
    localparam int END_WAIT     = 200;

    // directed stimulus: extremes, radix saturation from below and above, the empty item
    stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        // reset radix is ten
        '{1'b0, 5'd0,  32'h0000_0000, CHK_EMPTY, 80'd0},
        '{1'b0, 5'd0,  32'hFFFF_FFFF, CHK_EMPTY, 80'd0},
        '{1'b0, 5'd0,  32'h8000_0000, CHK_EMPTY, 80'd0},
        '{1'b0, 5'd0,  32'd1,         CHK_TEXT,  "1"},
        '{1'b0, 5'd0,  32'h7FFF_FFFF, CHK_TEXT,  "2147483647"},
        '{1'b0, 5'd0,  32'd9,         CHK_MODEL, 80'd0},
        '{1'b0, 5'd0,  32'd10,        CHK_MODEL, 80'd0},
        // hex digits, letters included
        '{1'b1, 5'd16, 32'd255,       CHK_TEXT,  "FF"},
        '{1'b0, 5'd0,  32'h7FFF_FFFF, CHK_TEXT,  "7FFFFFFF"},
        '{1'b0, 5'd0,  32'h000A_BCDE, CHK_MODEL, 80'd0},
        '{1'b0, 5'd0,  32'd15,        CHK_TEXT,  "F"},
        // binary: the longest run of all, 31 digits
        '{1'b1, 5'd2,  32'd5,         CHK_MODEL, 80'd0},
        '{1'b0, 5'd0,  32'h7FFF_FFFF, CHK_MODEL, 80'd0},
        '{1'b0, 5'd0,  32'd1,         CHK_TEXT,  "1"},
        // radix below two acts as two
        '{1'b1, 5'd0,  32'd6,         CHK_TEXT,  "110"},
        '{1'b1, 5'd1,  32'd7,         CHK_TEXT,  "111"},
        // radix above sixteen acts as sixteen
        '{1'b1, 5'd17, 32'd255,       CHK_TEXT,  "FF"},
        '{1'b1, 5'd31, 32'h7EDC_BA98, CHK_TEXT,  "7EDCBA98"},
        '{1'b0, 5'd0,  32'hFFFF_FFFB, CHK_EMPTY, 80'd0},
        // odd radixes
        '{1'b1, 5'd3,  32'h7FFF_FFFF, CHK_MODEL, 80'd0},
        '{1'b1, 5'd7,  32'd12345,     CHK_MODEL, 80'd0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [31:0]             value;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [RADIX_BITS-1:0]   cfg_data;
    logic                    digit_strobe;
    logic [CHAR_BITS-1:0]    digit_char;
    logic                    last_digit;
    logic                    empty_res;

    // digits still owed by the block, oldest first
    digit_result_t           pending_digits [$];
    // the bench's copy of the radix register
    logic [RADIX_BITS-1:0]   radix_shadow;
    int unsigned             mismatch_count;
    // when set, the sender never idles
    bit                      steady_sender;

    integer_to_radix_digits_unit #(
        .VALUE_BITS (32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .empty_res    (empty_res)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // ascii for one digit value
    function automatic logic [CHAR_BITS-1:0] ascii_of(input int unsigned d);
        if (d < 10)
            return 7'h30 + 7'(d);
        return 7'h41 + 7'(d - 10);
    endfunction

    // divide by the saturated radix, then queue the digits most significant first
    function automatic void predict_digits(input logic [31:0] v);
        int unsigned   base;
        int unsigned   rem;
        int unsigned   held [0:MAX_DIGITS-1];
        int            n;
        digit_result_t r;
        base = radix_shadow;
        if (base < 2)
            base = 2;
        else if (base > 16)
            base = 16;
        // zero and negative items give the single empty result
        if (v == 32'd0 || v[31]) begin
            r = '{digit_char: '0, last_digit: 1'b1, empty_res: 1'b1};
            pending_digits.push_back(r);
            return;
        end
        rem = v;
        n = 0;
        while (rem != 0 && n < MAX_DIGITS) begin
            held[n] = rem % base;
            rem = rem / base;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            r.digit_char = ascii_of(held[k]);
            r.last_digit = (k == 0);
            r.empty_res  = 1'b0;
            pending_digits.push_back(r);
        end
    endfunction

    // queue the digits typed into a table row, skipping the zero padding
    function automatic void expect_text(input logic [79:0] text);
        int            n;
        int            seen;
        digit_result_t r;
        n = 0;
        for (int b = 9; b >= 0; b--)
            if (text[b*8 +: 8] != 8'd0)
                n++;
        seen = 0;
        for (int b = 9; b >= 0; b--) begin
            if (text[b*8 +: 8] != 8'd0) begin
                seen++;
                r.digit_char = text[b*8 +: 7];
                r.last_digit = (seen == n);
                r.empty_res  = 1'b0;
                pending_digits.push_back(r);
            end
        end
    endfunction

    // hold start low and wait until every owed digit has come out
    task automatic drain_digits();
        if (start)
            start <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // radix writes only ever happen with the block idle
    task automatic write_radix(input logic [RADIX_BITS-1:0] r);
        drain_digits();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        radix_shadow = r;
        cfg_valid <= 1'b0;
    endtask

    // offer one item and wait for the block to take it
    task automatic send_item(input logic [31:0] v, input row_check_t chk,
                             input logic [79:0] text);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (chk)
            CHK_TEXT:  expect_text(text);
            CHK_EMPTY: predict_digits(32'd0);
            default:   predict_digits(v);
        endcase
    endtask

    // sender gap after an item: about a third of the time, now and then a long one
    task automatic sender_gap();
        int unsigned n;
        if (steady_sender || $urandom_range(99) >= 35)
            return;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
        start <= 1'b0;
        value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // random item mix: mostly positive values, some near the top, some not positive
    function automatic logic [31:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return {1'b0, 31'($urandom)};
        if (pick < 70)
            return 32'($urandom_range(1, 300));
        if (pick < 82)
            return 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
        if (pick < 95)
            return {1'b1, 31'($urandom)};
        return 32'd0;
    endfunction

    // radix for a random phase: mostly legal, sometimes the saturating codes
    function automatic logic [RADIX_BITS-1:0] random_radix();
        if ($urandom_range(99) < 80)
            return RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
        return RADIX_BITS'($urandom_range(0, 31));
    endfunction

    // result checker: every strobe must match the oldest owed digit
    always @(posedge clk) begin
        digit_result_t want;
        if (rst_n && digit_strobe) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit char %h last %b empty %b",
                         $time, digit_char, last_digit, empty_res);
                mismatch_count++;
            end
            else begin
                want = pending_digits.pop_front();
                if (digit_char !== want.digit_char) begin
                    $display("%0t: digit_char expected %h actual %h",
                             $time, want.digit_char, digit_char);
                    mismatch_count++;
                end
                if (last_digit !== want.last_digit) begin
                    $display("%0t: last_digit expected %b actual %b",
                             $time, want.last_digit, last_digit);
                    mismatch_count++;
                end
                if (empty_res !== want.empty_res) begin
                    $display("%0t: empty_res expected %b actual %b",
                             $time, want.empty_res, empty_res);
                    mismatch_count++;
                end
            end
        end
    end

    // main stimulus
    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        radix_shadow   = RADIX_RESET;
        mismatch_count = 0;
        steady_sender  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].set_radix)
                write_radix(directed_rows[i].radix);
            send_item(directed_rows[i].value, directed_rows[i].check,
                      directed_rows[i].text);
            sender_gap();
        end

        // random phases, one radix each
        for (int p = 0; p < NUM_PHASES; p++) begin
            // a calm stretch with the sender never pausing
            steady_sender = (p == 4 || p == 5);
            write_radix(random_radix());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender waits for the block to fall fully idle mid-phase
                if (p == 2 && i == 5)
                    drain_digits();
                send_item(random_value(), CHK_MODEL, 80'd0);
                sender_gap();
            end
        end

        // wind down and catch any stray strobes
        drain_digits();
        repeat (END_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i2rd_pkg.sv
rtl/i2rd_front.sv
rtl/i2rd_back.sv
rtl/integer_to_radix_digits_unit.sv
bench/testbench.sv
